### rtl/dgm_pkg.sv
package dgm_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int PIX_W          = 8;
  localparam int MAG_W          = 17;
  localparam int ROW_WIDTH_W    = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;

  // diagonal differences and their sum/difference
  localparam int DIFF_W = PIX_W + 1;
  localparam int GRAD_W = PIX_W + 2;
  // |g| <= 510, so g*g < 2^18 and the sum of two squares < 2^19
  localparam int SQ_W   = 18;
  localparam int SUM_W  = 19;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic [ROW_WIDTH_W-1:0]    ROW_WIDTH_RST    = 12'd960;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd1280;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_WIDTH    = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } tag_t;

endpackage

### rtl/dgm_pix_if.sv
interface dgm_pix_if;
  logic                      valid;
  logic                      ready;
  logic [dgm_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

### rtl/dgm_mag_if.sv
interface dgm_mag_if;
  logic                      valid;
  logic                      ready;
  logic [dgm_pkg::MAG_W-1:0] grad_mag;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output grad_mag, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input grad_mag, input row_end, input frame_end,
                  output ready);
endinterface

### rtl/dgm_front.sv
module dgm_front #(
  parameter int MAX_WIDTH  = dgm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dgm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dgm_pkg::PIX_W-1:0]           pixel,
  input  logic                                frame_start,
  input  logic [dgm_pkg::ROW_WIDTH_W-1:0]     row_width,
  input  logic [dgm_pkg::FRAME_HEIGHT_W-1:0]  frame_height,
  output dgm_pkg::tag_t                       tag,
  output logic signed [dgm_pkg::GRAD_W-1:0]   gx,
  output logic signed [dgm_pkg::GRAD_W-1:0]   gy
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RCW = $clog2(MAX_HEIGHT);
  localparam int RW  = (dgm_pkg::ROW_WIDTH_W > CW + 1) ? dgm_pkg::ROW_WIDTH_W : CW + 1;
  localparam int HW  = (dgm_pkg::FRAME_HEIGHT_W > RCW + 1) ? dgm_pkg::FRAME_HEIGHT_W
                                                           : RCW + 1;

  logic [dgm_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];

  logic [CW-1:0]  col;
  logic [RCW-1:0] row;
  logic [CW-1:0]  col_next;
  logic [RCW-1:0] row_next;
  logic [CW-1:0]  col_cur;
  logic [RCW-1:0] row_cur;
  logic [RW-1:0]  w_raw;
  logic [RW-1:0]  w_eff;
  logic [HW-1:0]  h_raw;
  logic [HW-1:0]  h_eff;
  logic           last_col;
  logic           last_row;
  logic           accept;

  logic [dgm_pkg::PIX_W-1:0] prev_pixel;
  logic [dgm_pkg::PIX_W-1:0] prev_above;

  // first stage: pixel, its left neighbour and the line store read
  logic                      a_busy;
  logic                      a_emit;
  logic                      a_row_end;
  logic                      a_frame_end;
  logic [dgm_pkg::PIX_W-1:0] a_pix;
  logic [dgm_pkg::PIX_W-1:0] a_left;
  logic [dgm_pkg::PIX_W-1:0] a_above;

  logic signed [dgm_pkg::DIFF_W-1:0] da;
  logic signed [dgm_pkg::DIFF_W-1:0] bc;

  function automatic logic signed [dgm_pkg::GRAD_W-1:0] GRAD_W_EXT(
    input logic signed [dgm_pkg::DIFF_W-1:0] d
  );
    return {d[dgm_pkg::DIFF_W-1], d};
  endfunction

  assign accept = en && in_valid;

  always_comb begin
    w_raw = RW'(row_width);
    h_raw = HW'(frame_height);
    if (w_raw < RW'(2))
      w_eff = RW'(2);
    else if (w_raw > RW'(MAX_WIDTH))
      w_eff = RW'(MAX_WIDTH);
    else
      w_eff = w_raw;
    if (h_raw < HW'(2))
      h_eff = HW'(2);
    else if (h_raw > HW'(MAX_HEIGHT))
      h_eff = HW'(MAX_HEIGHT);
    else
      h_eff = h_raw;

    col_cur  = frame_start ? '0 : col;
    row_cur  = frame_start ? '0 : row;
    last_col = RW'(col_cur) >= (w_eff - RW'(1));
    last_row = HW'(row_cur) >= (h_eff - HW'(1));

    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : RCW'(row_cur + RCW'(1));
    end else begin
      col_next = CW'(col_cur + CW'(1));
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_cur] <= pixel;
      a_above           <= line_mem[col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      prev_pixel <= '0;
      a_busy     <= 1'b0;
    end else if (en) begin
      a_busy <= in_valid;
      if (in_valid) begin
        col        <= col_next;
        row        <= row_next;
        prev_pixel <= pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix       <= pixel;
      a_left      <= prev_pixel;
      a_emit      <= (col_cur != '0) && (row_cur != '0);
      a_row_end   <= last_col;
      a_frame_end <= last_col && last_row;
    end
  end

  // window: upper-left = prev_above, upper-right = a_above,
  // lower-left = a_left, lower-right = a_pix
  assign da = $signed({1'b0, a_pix})   - $signed({1'b0, prev_above});
  assign bc = $signed({1'b0, a_above}) - $signed({1'b0, a_left});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_above <= '0;
      tag        <= '0;
    end else if (en) begin
      tag.valid     <= a_busy && a_emit;
      tag.row_end   <= a_row_end;
      tag.frame_end <= a_frame_end;
      if (a_busy)
        prev_above <= a_above;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx <= GRAD_W_EXT(da) + GRAD_W_EXT(bc);
      gy <= GRAD_W_EXT(da) - GRAD_W_EXT(bc);
    end
  end

endmodule

### rtl/dgm_sqrt_cell.sv
module dgm_sqrt_cell #(
  parameter int SW = 34,
  parameter int RB = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  dgm_pkg::tag_t        tag_in,
  input  logic [SW-1:0]        rad_in,
  input  logic [RB+1:0]        rem_in,
  input  logic [RB-1:0]        root_in,
  output dgm_pkg::tag_t        tag_out,
  output logic [SW-1:0]        rad_out,
  output logic [RB+1:0]        rem_out,
  output logic [RB-1:0]        root_out
);

  logic [RB+3:0] cur;
  logic [RB+3:0] trial;
  logic          fits;

  // bring down the next two radicand bits and try root*4+1
  assign cur   = {rem_in, rad_in[SW-1:SW-2]};
  assign trial = (RB + 4)'({root_in, 2'b01});
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst)
      tag_out <= '0;
    else if (en)
      tag_out <= tag_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[SW-3:0], 2'b00};
      rem_out  <= fits ? (RB + 2)'(cur - trial) : (RB + 2)'(cur);
      root_out <= {root_in[RB-2:0], fits};
    end
  end

endmodule

### rtl/diagonal_gradient_magnitude.sv
// Diagonal (Roberts cross) gradient magnitude over a raster pixel stream.
// pixels: one 8-bit grey value per transfer in raster order; frame_start
//   on a transfer restarts the row and column count at the top-left corner.
// magnitudes: one result per 2x2 window, i.e. for every pixel past the
//   first row and first column; sqrt((gx^2+gy^2)/4) with FRAC_BITS fraction
//   bits, truncated and saturated to 17 bits. row_end marks the last result
//   of a row, frame_end the last of the frame.
// Configuration: cfg_wr/cfg_addr/cfg_data write row_width (index 0) and
//   frame_height (index 1); change them only while the block is empty.
// Throughput is one pixel per clock while the receiver takes results. The
//   stages from a pixel transfer to its result: two front stages around the
//   line store read, a squaring stage, a summing stage, one square-root cell
//   per result bit (RB = FRAC_BITS + 9 cells), and the output register.
// Reset clears the counters and empties the pipeline; the line store keeps
//   its contents. While the receiver holds ready low with a result waiting,
//   the whole chain holds and pixels.ready is low.
module diagonal_gradient_magnitude #(
  parameter int MAX_WIDTH  = dgm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dgm_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = dgm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr,
  input  logic [dgm_pkg::CFG_INDEX_W-1:0]    cfg_addr,
  input  logic [dgm_pkg::CFG_DATA_W-1:0]     cfg_data,
  dgm_pix_if.sink                            pixels,
  dgm_mag_if.source                          magnitudes
);

  // radicand width (even) and number of root bits
  localparam int SW  = (FRAC_BITS >= 1) ? 18 + 2 * FRAC_BITS : 18;
  localparam int SH  = (FRAC_BITS >= 1) ? 2 * FRAC_BITS - 2 : 0;
  localparam int RB  = SW / 2;
  localparam int RBX = (RB > dgm_pkg::MAG_W) ? RB : dgm_pkg::MAG_W;

  logic [dgm_pkg::ROW_WIDTH_W-1:0]    row_width;
  logic [dgm_pkg::FRAME_HEIGHT_W-1:0] frame_height;

  logic en;

  dgm_pkg::tag_t                    b_tag;
  logic signed [dgm_pkg::GRAD_W-1:0] gx;
  logic signed [dgm_pkg::GRAD_W-1:0] gy;

  dgm_pkg::tag_t                  c_tag;
  logic [dgm_pkg::SQ_W-1:0]       sqx;
  logic [dgm_pkg::SQ_W-1:0]       sqy;
  logic signed [2*dgm_pkg::GRAD_W-1:0] sqx_full;
  logic signed [2*dgm_pkg::GRAD_W-1:0] sqy_full;

  dgm_pkg::tag_t                  d_tag;
  logic [dgm_pkg::SUM_W-1:0]      sum;

  dgm_pkg::tag_t  tag_c  [RB+1];
  logic [SW-1:0]  rad_c  [RB+1];
  logic [RB+1:0]  rem_c  [RB+1];
  logic [RB-1:0]  root_c [RB+1];

  logic [RBX-1:0] root_ext;

  assign en           = !magnitudes.valid || magnitudes.ready;
  assign pixels.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= dgm_pkg::ROW_WIDTH_RST;
      frame_height <= dgm_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (dgm_pkg::cfg_reg_t'(cfg_addr))
        dgm_pkg::REG_ROW_WIDTH:    row_width    <= cfg_data[dgm_pkg::ROW_WIDTH_W-1:0];
        dgm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  dgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (pixels.valid),
    .pixel        (pixels.pixel),
    .frame_start  (pixels.frame_start),
    .row_width    (row_width),
    .frame_height (frame_height),
    .tag          (b_tag),
    .gx           (gx),
    .gy           (gy)
  );

  assign sqx_full = gx * gx;
  assign sqy_full = gy * gy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_tag <= '0;
      d_tag <= '0;
    end else if (en) begin
      c_tag <= b_tag;
      d_tag <= c_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= sqx_full[dgm_pkg::SQ_W-1:0];
      sqy <= sqy_full[dgm_pkg::SQ_W-1:0];
      sum <= dgm_pkg::SUM_W'(sqx) + dgm_pkg::SUM_W'(sqy);
    end
  end

  // scale by 4^FRAC_BITS / 4 ahead of the root
  assign tag_c[0]  = d_tag;
  assign rad_c[0]  = (FRAC_BITS >= 1) ? (SW'(sum) << SH) : SW'(sum >> 2);
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < RB; i++) begin : g_cell
    dgm_sqrt_cell #(
      .SW (SW),
      .RB (RB)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tag_in   (tag_c[i]),
      .rad_in   (rad_c[i]),
      .rem_in   (rem_c[i]),
      .root_in  (root_c[i]),
      .tag_out  (tag_c[i+1]),
      .rad_out  (rad_c[i+1]),
      .rem_out  (rem_c[i+1]),
      .root_out (root_c[i+1])
    );
  end

  assign root_ext = RBX'(root_c[RB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitudes.valid <= 1'b0;
    end else if (en) begin
      magnitudes.valid <= tag_c[RB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magnitudes.row_end   <= tag_c[RB].row_end;
      magnitudes.frame_end <= tag_c[RB].frame_end;
      magnitudes.grad_mag  <= (root_ext > RBX'(dgm_pkg::MAG_MAX)) ? dgm_pkg::MAG_MAX
                                                                   : root_ext[dgm_pkg::MAG_W-1:0];
    end
  end

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    magnitudes.valid && magnitudes.frame_end |-> magnitudes.row_end)
    else $error("frame_end without row_end");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !magnitudes.valid)
    else $error("result valid straight after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    magnitudes.valid && !magnitudes.ready |=> $stable(magnitudes.grad_mag) || en)
    else $error("result changed while stalled");

endmodule

### dv/dgm_mag_checker.sv
module dgm_mag_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr,
  input  logic [dgm_pkg::CFG_INDEX_W-1:0] cfg_addr,
  input  logic [dgm_pkg::CFG_DATA_W-1:0]  cfg_data,
  dgm_pix_if                              pixels,
  dgm_mag_if                              magnitudes,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [dgm_pkg::MAG_W-1:0] grad_mag;
    logic                      row_end;
    logic                      frame_end;
  } mag_word_t;

  mag_word_t                            expected_mags[$];
  logic [dgm_pkg::PIX_W-1:0]            line_buf [dgm_pkg::MAX_WIDTH_DEF];
  logic [dgm_pkg::PIX_W-1:0]            left_pix;
  logic [dgm_pkg::PIX_W-1:0]            upper_left_pix;
  int                                   col;
  int                                   row;
  logic [dgm_pkg::ROW_WIDTH_W-1:0]      width_reg;
  logic [dgm_pkg::FRAME_HEIGHT_W-1:0]   height_reg;
  int                                   err_count = 0;

  function automatic logic [dgm_pkg::MAG_W-1:0] roberts_mag(input int ul, input int ur,
                                                           input int ll, input int lr);
    int                 da;
    int                 bc;
    int                 gx;
    int                 gy;
    longint unsigned    sq;
    longint unsigned    scaled;
    longint unsigned    root;
    longint unsigned    trial;
    da = lr - ul;
    bc = ur - ll;
    gx = da + bc;
    gy = da - bc;
    sq = 64'(gx * gx) + 64'(gy * gy);
    // (gx^2 + gy^2) / 4 scaled by 4^FRAC_BITS
    if (dgm_pkg::FRAC_BITS_DEF >= 1) begin
      scaled = sq << (2 * dgm_pkg::FRAC_BITS_DEF - 2);
    end else begin
      scaled = sq >> 2;
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled) begin
        root = trial;
      end
    end
    if (root > 64'(dgm_pkg::MAG_MAX)) begin
      return dgm_pkg::MAG_MAX;
    end
    return root[dgm_pkg::MAG_W-1:0];
  endfunction

  task automatic take_pixel(input logic [dgm_pkg::PIX_W-1:0] pix, input logic restart);
    int                        w;
    int                        h;
    logic [dgm_pkg::PIX_W-1:0] above;
    bit                        last_col;
    bit                        last_row;
    mag_word_t                 res;
    w = int'(width_reg);
    h = int'(height_reg);
    if (w < 2) w = 2;
    if (w > dgm_pkg::MAX_WIDTH_DEF) w = dgm_pkg::MAX_WIDTH_DEF;
    if (h < 2) h = 2;
    if (h > dgm_pkg::MAX_HEIGHT_DEF) h = dgm_pkg::MAX_HEIGHT_DEF;
    if (restart) begin
      col = 0;
      row = 0;
    end
    if (col >= dgm_pkg::MAX_WIDTH_DEF) col = 0;
    above    = line_buf[col];
    last_col = col >= w - 1;
    last_row = row >= h - 1;
    // a window closes on every pixel past the first row and column
    if (col >= 1 && row >= 1) begin
      res.grad_mag  = roberts_mag(upper_left_pix, above, left_pix, pix);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      expected_mags.push_back(res);
    end
    line_buf[col]  = pix;
    left_pix       = pix;
    upper_left_pix = above;
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end else begin
      col++;
    end
  endtask

  function automatic void flag(input string field, input int exp_val, input int act_val);
    err_count++;
    $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
  endfunction

  task automatic check_result();
    mag_word_t res;
    if (expected_mags.size() == 0) begin
      err_count++;
      $error("unexpected magnitude transfer: grad_mag %0d", magnitudes.grad_mag);
    end else begin
      res = expected_mags.pop_front();
      if (magnitudes.grad_mag !== res.grad_mag) begin
        flag("grad_mag", res.grad_mag, magnitudes.grad_mag);
      end
      if (magnitudes.row_end !== res.row_end) begin
        flag("row_end", res.row_end, magnitudes.row_end);
      end
      if (magnitudes.frame_end !== res.frame_end) begin
        flag("frame_end", res.frame_end, magnitudes.frame_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      col            = 0;
      row            = 0;
      left_pix       = '0;
      upper_left_pix = '0;
      width_reg      = dgm_pkg::ROW_WIDTH_RST;
      height_reg     = dgm_pkg::FRAME_HEIGHT_RST;
      expected_mags.delete();
    end else begin
      if (cfg_wr) begin
        case (dgm_pkg::cfg_reg_t'(cfg_addr))
          dgm_pkg::REG_ROW_WIDTH: begin
            width_reg = cfg_data[dgm_pkg::ROW_WIDTH_W-1:0];
          end
          dgm_pkg::REG_FRAME_HEIGHT: begin
            height_reg = cfg_data[dgm_pkg::FRAME_HEIGHT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pixels.valid && pixels.ready) begin
        take_pixel(pixels.pixel, pixels.frame_start);
      end
      if (magnitudes.valid && magnitudes.ready) begin
        check_result();
      end
    end
    pending <= expected_mags.size();
    errors  <= err_count;
  end

endmodule

### dv/tb_diagonal_gradient_magnitude.sv
module tb_diagonal_gradient_magnitude;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 460;
  localparam int QUIET_FROM    = 380;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_wr;
  logic [dgm_pkg::CFG_INDEX_W-1:0] cfg_addr;
  logic [dgm_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                              errors;
  int                              pending;
  bit                              src_idle;
  bit                              sink_idle;
  bit                              hold_req;
  int                              eff_width;

  dgm_pix_if pix_ch ();
  dgm_mag_if mag_ch ();

  diagonal_gradient_magnitude i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .pixels     (pix_ch),
    .magnitudes (mag_ch)
  );

  dgm_mag_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .pixels     (pix_ch),
    .magnitudes (mag_ch),
    .errors     (errors),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // magnitude receiver: random stalls, plus one long hold-off on request
  initial begin
    mag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        mag_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        mag_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(posedge clk);
      end else begin
        mag_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int clamp_width(input int data);
    int w;
    w = data & 'hFFF;
    if (w < 2) w = 2;
    if (w > dgm_pkg::MAX_WIDTH_DEF) w = dgm_pkg::MAX_WIDTH_DEF;
    return w;
  endfunction

  task automatic push_pixel(input logic [dgm_pkg::PIX_W-1:0] pix, input logic restart);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.frame_start <= restart;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  task automatic send_run(input int n, input bit restart, input bit noisy);
    logic [dgm_pkg::PIX_W-1:0] pix;
    bit                        fs;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: pix = '0;
        1: pix = '1;
        default: pix = dgm_pkg::PIX_W'($urandom_range(0, 255));
      endcase
      fs = (i == 0) ? restart : (noisy && $urandom_range(0, 63) == 0);
      push_pixel(pix, fs);
    end
  endtask

  // hold off until every expected magnitude is out and the pipeline is empty
  task automatic drain_pipeline();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input int w_data, input int h_data);
    cfg_wr   <= 1'b1;
    cfg_addr <= dgm_pkg::REG_ROW_WIDTH;
    cfg_data <= dgm_pkg::CFG_DATA_W'(w_data);
    @(posedge clk);
    cfg_addr <= dgm_pkg::REG_FRAME_HEIGHT;
    cfg_data <= dgm_pkg::CFG_DATA_W'(h_data);
    @(posedge clk);
    cfg_wr    <= 1'b0;
    eff_width  = clamp_width(w_data);
  endtask

  initial begin : stimulus
    logic [dgm_pkg::PIX_W-1:0] dir_pix [23];
    int                        rnd_sent;
    int                        w_data;
    int                        h_data;
    int                        n;
    bit                        restart;
    bit                        first_phase;

    // 4x3 frame with full-scale diagonals in both directions and a zero-gradient window,
    // then a frame entered by wrap-around, then a restart mid-frame
    dir_pix = '{8'd0, 8'd255, 8'd0, 8'd255,
                8'd255, 8'd255, 8'd0, 8'd0,
                8'd0, 8'd0, 8'd255, 8'd255,
                8'd1, 8'd2, 8'd3, 8'd4, 8'd5,
                8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60};

    rst                <= 1'b1;
    cfg_wr             <= 1'b0;
    cfg_addr           <= dgm_pkg::REG_ROW_WIDTH;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    src_idle            = 1'b1;
    sink_idle           = 1'b1;
    hold_req            = 1'b0;
    eff_width           = 960;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_geometry(4, 3);
    for (int i = 0; i < 23; i++) begin
      push_pixel(dir_pix[i], i == 0 || i == 17);
    end

    // widths and heights below the legal floor clamp to 2
    drain_pipeline();
    set_geometry(1, 0);
    send_run(9, 1'b1, 1'b0);

    // height above the limit clamps; stop part-way through the second row
    drain_pipeline();
    set_geometry(10, 8191);
    send_run(17, 1'b1, 1'b0);

    // lower the width mid-row: the row ends at once
    drain_pipeline();
    set_geometry(3, 8191);
    send_run(30, 1'b0, 1'b0);

    // lower the height mid-frame: the current row closes the frame
    drain_pipeline();
    set_geometry(2, 2);
    send_run(12, 1'b0, 1'b0);

    rnd_sent    = 0;
    first_phase = 1'b1;
    while (rnd_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w_data = $urandom_range(0, 1);
        1: w_data = $urandom_range(13, 80);
        2: w_data = 4096 + $urandom_range(2, 10);
        default: w_data = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0: h_data = $urandom_range(0, 1);
        1: h_data = 4096 + $urandom_range(2, 6);
        default: h_data = $urandom_range(2, 6);
      endcase
      if (first_phase) begin
        // short rows, so that results back up during the hold-off
        w_data = $urandom_range(2, 12);
      end
      // carry on the running frame only where no unwritten column can be read
      restart = !(clamp_width(w_data) <= eff_width && $urandom_range(0, 2) == 0);
      drain_pipeline();
      set_geometry(w_data, h_data);
      if (rnd_sent >= QUIET_FROM) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
      end
      if (first_phase) begin
        first_phase = 1'b0;
        hold_req    = 1'b1;
        send_run(75, 1'b1, 1'b1);
        drain_pipeline();
        send_run(75, 1'b0, 1'b1);
        rnd_sent += 150;
      end else begin
        n = $urandom_range(1, 2 * clamp_width(w_data) * 6 + 2);
        if (n > 200) n = 200;
        if (n > RANDOM_ITEMS - rnd_sent) n = RANDOM_ITEMS - rnd_sent;
        send_run(n, restart, 1'b1);
        rnd_sent += n;
      end
    end

    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
